// ===== rtl/core/lcdw_pkg.sv =====
// Shared types, constants and digit helpers for the character LCD write engine.
package lcdw_pkg;

    typedef enum logic [1:0] {
        CMD_COMMAND = 2'd0,
        CMD_CHAR    = 2'd1,
        CMD_CURSOR  = 2'd2,
        CMD_NUMBER  = 2'd3
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 3;

    localparam logic       REG_BUS_MODE = 1'b0;
    localparam logic [7:0] SET_DDRAM    = 8'h80;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [2:0] LAST_DIGIT   = 3'd4;

    typedef struct packed {
        logic        rs;
        logic        is_num;
        logic [15:0] data;
    } entry_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

    function automatic logic [16:0] pow10(input logic [2:0] idx);
        logic [16:0] p;
        case (idx)
            3'd0:    p = 17'd10000;
            3'd1:    p = 17'd1000;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd10;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] digit_of(input logic [15:0] rest, input logic [2:0] idx);
        logic [16:0] p;
        logic [3:0]  d;
        p = pow10(idx);
        d = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({5'd0, rest} >= 21'(k) * {4'd0, p})
            begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [15:0] residue(input logic [15:0] rest, input logic [2:0] idx,
                                            input logic [3:0] d);
        logic [20:0] r;
        r = {5'd0, rest} - {17'd0, d} * {4'd0, pow10(idx)};
        return r[15:0];
    endfunction

endpackage

// ===== rtl/core/lcdw_front.sv =====
// Request intake: accepts items and turns each into a queue entry.
module lcdw_front (
    input  logic                  push,
    input  logic [1:0]            cmd,
    input  logic [15:0]           value,
    input  logic [5:0]            column,
    input  logic                  row,
    input  lcdw_pkg::q_status_t   q_status,
    output logic                  q_write,
    output lcdw_pkg::entry_t      q_entry
);
    import lcdw_pkg::*;

    assign q_write = push && !q_status.full;

    always_comb
    begin
        q_entry.rs     = 1'b0;
        q_entry.is_num = 1'b0;
        q_entry.data   = {8'd0, value[7:0]};
        case (cmd_t'(cmd))
            CMD_COMMAND:
            begin
                q_entry.rs   = 1'b0;
                q_entry.data = {8'd0, value[7:0]};
            end
            CMD_CHAR:
            begin
                q_entry.rs   = 1'b1;
                q_entry.data = {8'd0, value[7:0]};
            end
            CMD_CURSOR:
            begin
                // column < 64, so column + row*64 is just {row, column}
                q_entry.rs   = 1'b0;
                q_entry.data = {8'd0, SET_DDRAM | {1'b0, row, column}};
            end
            CMD_NUMBER:
            begin
                q_entry.rs     = 1'b1;
                q_entry.is_num = 1'b1;
                q_entry.data   = value;
            end
            default:
            begin
                q_entry.rs   = 1'b0;
                q_entry.data = {8'd0, value[7:0]};
            end
        endcase
    end

endmodule

// ===== rtl/core/lcdw_queue.sv =====
// Small FIFO of classified requests between intake and serializer.
module lcdw_queue #(
    parameter int DEPTH = lcdw_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  lcdw_pkg::entry_t      wr_entry,
    input  logic                  rd_en,
    output lcdw_pkg::entry_t      rd_entry,
    output lcdw_pkg::q_status_t   status
);
    import lcdw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full     = (count_reg == CNT_FULL);
    assign status.nonempty = (count_reg != '0);
    assign rd_entry        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/core/lcdw_back.sv =====
// Serializer: expands queued requests into bytes, digits and nibble transfers.
module lcdw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  bus_mode,
    input  lcdw_pkg::q_status_t   q_status,
    input  lcdw_pkg::entry_t      q_entry,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic                  register_select,
    output logic [7:0]            bus_value,
    output logic                  last
);
    import lcdw_pkg::*;

    logic        cur_valid_reg, cur_valid_next;
    logic        cur_rs_reg, cur_rs_next;
    logic        cur_num_reg, cur_num_next;
    logic [15:0] rest_reg, rest_next;
    logic [2:0]  idx_reg, idx_next;
    logic        nib_reg, nib_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_rs_reg, out_rs_next;
    logic [7:0]  out_value_reg, out_value_next;
    logic        out_last_reg, out_last_next;

    logic [3:0]  digit;
    logic [7:0]  cur_byte;
    logic        byte_done;
    logic        item_end;
    logic        issue;
    logic        load;

    assign digit     = digit_of(rest_reg, idx_reg);
    assign cur_byte  = cur_num_reg ? (ASCII_ZERO | {4'd0, digit}) : rest_reg[7:0];
    assign byte_done = bus_mode || nib_reg;
    assign item_end  = byte_done && (!cur_num_reg || (idx_reg == LAST_DIGIT));
    assign issue     = cur_valid_reg && (!out_valid_reg || pop);
    assign load      = q_status.nonempty && (!cur_valid_reg || (issue && item_end));
    assign q_pop     = load;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_rs_next    = cur_rs_reg;
        cur_num_next   = cur_num_reg;
        rest_next      = rest_reg;
        idx_next       = idx_reg;
        nib_next       = nib_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            cur_rs_next    = q_entry.rs;
            cur_num_next   = q_entry.is_num;
            rest_next      = q_entry.data;
            idx_next       = '0;
            nib_next       = 1'b0;
        end
        else if (issue)
        begin
            if (item_end)
            begin
                cur_valid_next = 1'b0;
                idx_next       = '0;
                nib_next       = 1'b0;
            end
            else if (byte_done)
            begin
                nib_next  = 1'b0;
                idx_next  = idx_reg + 1'b1;
                rest_next = residue(rest_reg, idx_reg, digit);
            end
            else
            begin
                nib_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rs_next    = out_rs_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            out_rs_next    = cur_rs_reg;
            out_last_next  = item_end;
            if (bus_mode)
            begin
                out_value_next = cur_byte;
            end
            else if (nib_reg)
            begin
                out_value_next = {cur_byte[3:0], 4'd0};
            end
            else
            begin
                out_value_next = {cur_byte[7:4], 4'd0};
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            nib_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            nib_reg       <= nib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_rs_reg    <= cur_rs_next;
        cur_num_reg   <= cur_num_next;
        rest_reg      <= rest_next;
        out_rs_reg    <= out_rs_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign empty           = !out_valid_reg;
    assign register_select = out_rs_reg;
    assign bus_value       = out_value_reg;
    assign last            = out_last_reg;

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.nonempty)
        else $error("queue popped while empty");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !cur_valid_reg |-> (!nib_reg && (idx_reg == 3'd0)))
        else $error("serializer counters not cleared when idle");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && cur_num_reg |-> (idx_reg <= LAST_DIGIT))
        else $error("digit index out of range");

    a_rest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && cur_num_reg && (idx_reg != 3'd0)
            |-> ({1'b0, rest_reg} < pow10(idx_reg - 1'b1)))
        else $error("remainder exceeds previous digit weight");

endmodule

// ===== rtl/core/character_lcd_write_engine.sv =====
// Character LCD write engine: request intake, queue, serializer and config register.
//
// Each pushed request (command byte, character byte, cursor move or 16-bit
// number) is turned into bus transfers: a byte request is one transfer in 8-bit
// mode and two in 4-bit mode, a number five or ten (five ASCII digits, leading
// zeros). The serializer sets the rate: it emits one transfer per clock into the
// output register while that register is empty or popped; the intake accepts one
// request per cycle while the request queue (QUEUE_DEPTH entries) has room.
// bus_mode (address 0) selects 4-bit nibble (0) or 8-bit (1) transfers and
// must only be written while the engine is idle.
module character_lcd_write_engine #(
    parameter int QUEUE_DEPTH = lcdw_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcdw_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    cmd,
    input  logic [15:0]                   value,
    input  logic [5:0]                    column,
    input  logic                          row,
    input  logic                          pop,
    output logic                          empty,
    output logic                          register_select,
    output logic [7:0]                    bus_value,
    output logic                          last
);
    import lcdw_pkg::*;

    logic      bus_mode_reg, bus_mode_next;
    logic      reg_hit;
    q_status_t q_status;
    entry_t    wr_entry;
    entry_t    rd_entry;
    logic      q_write;
    logic      q_pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_BUS_MODE);
    assign prdata  = reg_hit ? {31'd0, bus_mode_reg} : 32'd0;

    always_comb
    begin
        bus_mode_next = bus_mode_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            bus_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg <= 1'b0;
        end
        else
        begin
            bus_mode_reg <= bus_mode_next;
        end
    end

    assign full = q_status.full;

    lcdw_front u_front (
        .push     (push),
        .cmd      (cmd),
        .value    (value),
        .column   (column),
        .row      (row),
        .q_status (q_status),
        .q_write  (q_write),
        .q_entry  (wr_entry)
    );

    lcdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_write),
        .wr_entry (wr_entry),
        .rd_en    (q_pop),
        .rd_entry (rd_entry),
        .status   (q_status)
    );

    lcdw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .bus_mode        (bus_mode_reg),
        .q_status        (q_status),
        .q_entry         (rd_entry),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .register_select (register_select),
        .bus_value       (bus_value),
        .last            (last)
    );

endmodule
